>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

>>> rtl/core/pace_pkg.sv
package pace_pkg;

    localparam int ATTR_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int SEQ_MAX  = 4;
    localparam int SEQ_IW   = $clog2(SEQ_MAX);
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_LW     = $clog2(Q_DEPTH + 1);

    // attribute encodings
    localparam logic [ATTR_W-1:0] ATTR_NORMAL  = 13'h0800;
    localparam logic [ATTR_W-1:0] ATTR_BGBLACK = 13'h1000;

    // control bytes
    localparam logic [BYTE_W-1:0] B_RVS_ON   = 8'h12;
    localparam logic [BYTE_W-1:0] B_RVS_OFF  = 8'h92;
    localparam logic [BYTE_W-1:0] B_FLASH_ON = 8'h0F;
    localparam logic [BYTE_W-1:0] B_FLASH_OFF = 8'h8F;
    localparam logic [BYTE_W-1:0] B_ULINE_ON = 8'h02;
    localparam logic [BYTE_W-1:0] B_ULINE_OFF = 8'h82;
    localparam logic [BYTE_W-1:0] B_DKGRAY_W = 8'h98;
    localparam logic [BYTE_W-1:0] B_CYAN_W   = 8'h97;

    localparam logic [3:0] FG_DKGRAY = 4'd8;
    localparam logic [3:0] FG_CYAN   = 4'd3;

    typedef struct packed {
        logic [SEQ_MAX-1:0][BYTE_W-1:0] bytes;
        logic [SEQ_IW-1:0]              last_idx;
    } t_seq;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [Q_LW-1:0] level;
    } t_q_status;

    function automatic logic [BYTE_W-1:0] color_byte(input logic [3:0] fg, input logic wide);
        logic [BYTE_W-1:0] b;
        case (fg)
            4'd0:    b = 8'h90;
            4'd1:    b = 8'h1F;
            4'd2:    b = 8'h1E;
            4'd3:    b = 8'h98;
            4'd4:    b = 8'h1C;
            4'd5:    b = 8'h81;
            4'd6:    b = 8'h95;
            4'd7:    b = 8'h9B;
            4'd8:    b = 8'h97;
            4'd9:    b = 8'h9A;
            4'd10:   b = 8'h99;
            4'd11:   b = 8'h9F;
            4'd12:   b = 8'h96;
            4'd13:   b = 8'h9C;
            4'd14:   b = 8'h9E;
            default: b = 8'h05;
        endcase
        if (wide && fg == FG_CYAN) begin
            b = B_CYAN_W;
        end else if (wide && fg == FG_DKGRAY) begin
            b = B_DKGRAY_W;
        end
        return b;
    endfunction

endpackage

>>> rtl/core/petscii_attr_change_encoder.sv
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+----------------------------------
// in      | input     | i_in_valid / o_in_stall   | i_new_attr, i_current_attr
// out     | output    | o_out_valid / i_out_stall | o_out_byte, o_last
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (wide_mode)
//
// An attribute pair is translated and packed in the cycle it is taken; one byte
// leaves per cycle while the receiver does not stall, and an item holds 1 to 4
// change bytes. A pair with no change emits nothing. The first byte passes through
// the queue and then the output register before it reaches the port. A two-entry
// queue sits between the two halves; o_in_stall is high only while it is full.
// Reset is synchronous, active low, and sets wide_mode to narrow.
`include "assert_macros.svh"

module petscii_attr_change_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pace_pkg::ATTR_W-1:0] i_new_attr,
    input  logic [pace_pkg::ATTR_W-1:0] i_current_attr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pace_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    logic                r_wide_mode;
    pace_pkg::t_seq      front_seq;
    logic                front_has;
    logic                push;
    logic                pop;
    pace_pkg::t_seq      q_head;
    pace_pkg::t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wide_mode <= i_cfg_data;
        end
    end

    pace_front u_front (
        .i_new_attr     (i_new_attr),
        .i_current_attr (i_current_attr),
        .i_wide         (r_wide_mode),
        .o_seq          (front_seq),
        .o_has_bytes    (front_has)
    );

    assign o_in_stall = q_status.full;
    // drop transactions that need no bytes
    assign push = i_in_valid && !o_in_stall && front_has;

    pace_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_seq),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    pace_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_status.empty),
        .i_head       (q_head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_byte       (o_out_byte),
        .o_last       (o_last)
    );

    `ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n,
        q_status.level > pace_pkg::Q_LW'(pace_pkg::Q_DEPTH), "queue level beyond depth")
    `ASSERT_CLK(a_no_gap, i_clk, i_rst_n,
        o_out_valid && !o_last && !i_out_stall |=> o_out_valid, "gap inside a byte sequence")
    `ASSERT_CLK(a_pop_last, i_clk, i_rst_n,
        pop |=> o_out_valid && o_last, "queue entry retired without its last byte")

endmodule

>>> rtl/core/pace_front.sv
module pace_front (
    input  logic [pace_pkg::ATTR_W-1:0] i_new_attr,
    input  logic [pace_pkg::ATTR_W-1:0] i_current_attr,
    input  logic                        i_wide,
    output pace_pkg::t_seq              o_seq,
    output logic                        o_has_bytes
);

    // bit positions of the attribute word
    localparam int B_HIGH  = 3;
    localparam int B_BLINK = 7;
    localparam int B_RVS   = 8;
    localparam int B_ULINE = 9;
    localparam int B_BGBR  = 10;

    function automatic logic [pace_pkg::ATTR_W-1:0] translate(
        input logic [pace_pkg::ATTR_W-1:0] a,
        input logic                        wide
    );
        logic [pace_pkg::ATTR_W-1:0] t;
        logic [pace_pkg::ATTR_W-1:0] r;
        t = a;
        r = '0;
        if (a == pace_pkg::ATTR_NORMAL) begin
            t = 13'h0007;
        end else if (a == pace_pkg::ATTR_BGBLACK) begin
            t = '0;
        end
        if (t[B_RVS]) begin
            t[6:4] = 3'b000;
        end else if (t[6:4] != 3'b000 || t[B_BGBR]) begin
            // background color moves to the foreground under reverse
            r[B_RVS]   = 1'b1;
            r[B_BLINK] = t[B_BLINK];
            r[B_HIGH]  = t[B_BGBR];
            r[2:0]     = t[6:4];
            t = r;
        end
        if (!wide) begin
            t[B_BLINK] = 1'b0;
            t[B_ULINE] = 1'b0;
        end
        return t;
    endfunction

    logic [pace_pkg::ATTR_W-1:0] want;
    logic [pace_pkg::ATTR_W-1:0] cur;
    logic                        cur_blink;
    logic                        cur_uline;
    logic [3:0]                  cur_fg;
    logic [pace_pkg::SEQ_MAX-1:0]                     slot_en;
    logic [pace_pkg::SEQ_MAX-1:0][pace_pkg::BYTE_W-1:0] slot_byte;
    logic [pace_pkg::SEQ_IW:0]   n;

    assign want = translate(i_new_attr, i_wide);
    assign cur  = translate(i_current_attr, i_wide);

    always_comb begin
        cur_blink = cur[B_BLINK];
        cur_uline = cur[B_ULINE];
        cur_fg    = cur[3:0];
        slot_en   = '0;
        slot_byte = '0;

        if (want[B_RVS] && !cur[B_RVS]) begin
            slot_en[0]   = 1'b1;
            slot_byte[0] = pace_pkg::B_RVS_ON;
            cur_uline    = 1'b0;
            cur_fg       = 4'd0;
        end else if (!want[B_RVS] && cur[B_RVS]) begin
            slot_en[0]   = 1'b1;
            slot_byte[0] = pace_pkg::B_RVS_OFF;
            cur_uline    = 1'b0;
            cur_fg       = {cur[B_BGBR], cur[6:4]};
        end

        if (want[B_BLINK] != cur_blink) begin
            slot_en[1]   = 1'b1;
            slot_byte[1] = want[B_BLINK] ? pace_pkg::B_FLASH_ON : pace_pkg::B_FLASH_OFF;
        end

        if (want[B_ULINE] != cur_uline) begin
            slot_en[2]   = 1'b1;
            slot_byte[2] = want[B_ULINE] ? pace_pkg::B_ULINE_ON : pace_pkg::B_ULINE_OFF;
        end

        if (want[3:0] != cur_fg) begin
            slot_en[3]   = 1'b1;
            slot_byte[3] = pace_pkg::color_byte(want[3:0], i_wide);
        end
    end

    // pack the present bytes to the front of the sequence
    always_comb begin
        o_seq.bytes = '0;
        n           = '0;
        for (int k = 0; k < pace_pkg::SEQ_MAX; k++) begin
            if (slot_en[k]) begin
                o_seq.bytes[n[pace_pkg::SEQ_IW-1:0]] = slot_byte[k];
                n = n + 1'b1;
            end
        end
        o_seq.last_idx = n[pace_pkg::SEQ_IW-1:0] - 1'b1;
        o_has_bytes    = (n != '0);
    end

endmodule

>>> rtl/core/pace_queue.sv
module pace_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pace_pkg::t_seq      i_data,
    input  logic                i_pop,
    output pace_pkg::t_seq      o_head,
    output pace_pkg::t_q_status o_status
);

    pace_pkg::t_seq                r_mem [pace_pkg::Q_DEPTH];
    logic [pace_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [pace_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [pace_pkg::Q_LW-1:0]     r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == pace_pkg::Q_AW'(pace_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == pace_pkg::Q_AW'(pace_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == pace_pkg::Q_LW'(pace_pkg::Q_DEPTH));
    assign o_status.level = r_level;

endmodule

>>> rtl/core/pace_back.sv
module pace_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  pace_pkg::t_seq              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pace_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_last
);

    logic [pace_pkg::SEQ_IW-1:0] r_idx;
    logic [pace_pkg::SEQ_IW-1:0] n_idx;
    logic                        r_valid;
    logic                        n_valid;
    logic [pace_pkg::BYTE_W-1:0] r_byte;
    logic                        r_last;
    logic                        load;
    logic                        at_end;

    assign load   = i_head_valid && (!r_valid || !i_stall);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_end ? '0 : r_idx + 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // hold the byte while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= at_end;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

>>> bench/petscii_attr_change_encoder_tb.sv
module petscii_attr_change_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [12:0] BIT_HIGH   = 13'h008;
    localparam logic [12:0] BIT_BLINK  = 13'h080;
    localparam logic [12:0] BIT_REV    = 13'h100;
    localparam logic [12:0] BIT_ULINE  = 13'h200;
    localparam logic [12:0] BIT_BRIGHT = 13'h400;
    localparam logic [12:0] MASK_BG    = 13'h070;
    localparam logic [12:0] MASK_FG    = 13'h00F;
    localparam logic [12:0] TERM_GRAY  = 13'h007;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_PAIRS  = 102;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_FROM   = 250;
    localparam int QUIET_TO     = 340;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_ctl_byte;

    typedef struct packed {
        logic            wide;
        logic [12:0]     want;
        logic [12:0]     cur;
        logic            typed;
        logic [2:0]      n;
        logic [3:0][7:0] seq;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [12:0] i_new_attr     = '0;
    logic [12:0] i_current_attr = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data     = 1'b0;

    t_ctl_byte   pending_bytes [$];
    t_ctl_byte   got;
    logic        wide_mode      = 1'b0;
    int          pair_cnt       = 0;
    int          mismatch_cnt   = 0;
    int          cycle_cnt      = 0;
    int          hold_left      = 0;
    logic        hold_done      = 1'b0;
    logic        quiet;

    assign quiet = (pair_cnt >= QUIET_FROM) && (pair_cnt < QUIET_TO);

    petscii_attr_change_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_new_attr     (i_new_attr),
        .i_current_attr (i_current_attr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [12:0] bg_as_fg(input logic [12:0] a);
        return (a & BIT_BLINK) | (((a & BIT_BRIGHT) != 0) ? BIT_HIGH : 13'h0)
             | ((a & MASK_BG) >> 4);
    endfunction

    function automatic logic [12:0] fg_as_bg(input logic [12:0] a);
        return BIT_REV | (((a & BIT_HIGH) != 0) ? BIT_BRIGHT : 13'h0) | (a & BIT_BLINK)
             | ((a & 13'h7) << 4);
    endfunction

    function automatic logic [12:0] to_terminal(input logic [12:0] a, input logic wide);
        logic [12:0] t;
        t = a;
        if (t == pace_pkg::ATTR_NORMAL) begin
            t = TERM_GRAY;
        end else if (t == pace_pkg::ATTR_BGBLACK) begin
            t = '0;
        end
        if ((t & BIT_REV) != 0) begin
            t &= ~MASK_BG;
        end else if ((t & (MASK_BG | BIT_BRIGHT)) != 0) begin
            t = BIT_REV | bg_as_fg(t);
        end
        if (!wide) begin
            t &= ~(BIT_BLINK | BIT_ULINE);
        end
        return t;
    endfunction

    function automatic logic [7:0] pet_color(input logic [3:0] fg, input logic wide);
        logic [7:0] b;
        case (fg)
            4'd0:    b = 8'h90;
            4'd1:    b = 8'h1F;
            4'd2:    b = 8'h1E;
            4'd3:    b = 8'h98;
            4'd4:    b = 8'h1C;
            4'd5:    b = 8'h81;
            4'd6:    b = 8'h95;
            4'd7:    b = 8'h9B;
            4'd8:    b = 8'h97;
            4'd9:    b = 8'h9A;
            4'd10:   b = 8'h99;
            4'd11:   b = 8'h9F;
            4'd12:   b = 8'h96;
            4'd13:   b = 8'h9C;
            4'd14:   b = 8'h9E;
            default: b = 8'h05;
        endcase
        // wide mode swaps dark gray and cyan
        if (wide && fg == pace_pkg::FG_CYAN) begin
            b = pace_pkg::B_CYAN_W;
        end else if (wide && fg == pace_pkg::FG_DKGRAY) begin
            b = pace_pkg::B_DKGRAY_W;
        end
        return b;
    endfunction

    function automatic int predict_change(input logic [12:0] new_raw, input logic [12:0] cur_raw,
                                          input logic wide, output logic [3:0][7:0] seq);
        logic [12:0] tgt;
        logic [12:0] now;
        int          n;
        tgt = to_terminal(new_raw, wide);
        now = to_terminal(cur_raw, wide);
        n   = 0;
        seq = '0;
        // a reverse toggle remaps the current attribute before the later compares
        if ((tgt & BIT_REV) != 0) begin
            if ((now & BIT_REV) == 0) begin
                seq[n] = pace_pkg::B_RVS_ON;
                n++;
                now = fg_as_bg(now);
            end
        end else if ((now & BIT_REV) != 0) begin
            seq[n] = pace_pkg::B_RVS_OFF;
            n++;
            now = bg_as_fg(now);
        end
        if ((tgt & BIT_BLINK) != 0 && (now & BIT_BLINK) == 0) begin
            seq[n] = pace_pkg::B_FLASH_ON;
            n++;
        end else if ((tgt & BIT_BLINK) == 0 && (now & BIT_BLINK) != 0) begin
            seq[n] = pace_pkg::B_FLASH_OFF;
            n++;
        end
        if ((tgt & BIT_ULINE) != 0 && (now & BIT_ULINE) == 0) begin
            seq[n] = pace_pkg::B_ULINE_ON;
            n++;
        end else if ((tgt & BIT_ULINE) == 0 && (now & BIT_ULINE) != 0) begin
            seq[n] = pace_pkg::B_ULINE_OFF;
            n++;
        end
        if ((tgt & MASK_FG) != (now & MASK_FG)) begin
            seq[n] = pet_color(tgt[3:0], wide);
            n++;
        end
        return n;
    endfunction

    // n < 0 leaves the row to the predictor
    function automatic t_dir_row vec(input logic w, input logic [12:0] a, input logic [12:0] c,
                                     input int n, input logic [7:0] b0 = 8'h0,
                                     input logic [7:0] b1 = 8'h0, input logic [7:0] b2 = 8'h0,
                                     input logic [7:0] b3 = 8'h0);
        t_dir_row r;
        r.wide  = w;
        r.want  = a;
        r.cur   = c;
        r.typed = (n >= 0);
        r.n     = (n >= 0) ? 3'(n) : 3'd0;
        r.seq   = {b3, b2, b1, b0};
        return r;
    endfunction

    function automatic logic [12:0] pick_attr();
        case ($urandom_range(9))
            0:       return pace_pkg::ATTR_NORMAL;
            1:       return pace_pkg::ATTR_BGBLACK;
            2, 3, 4: return 13'($urandom) & 13'h03CF;
            default: return 13'($urandom);
        endcase
    endfunction

    task automatic send_pair(input logic [12:0] want, input logic [12:0] cur,
                             input logic typed, input int typed_n,
                             input logic [3:0][7:0] typed_seq);
        logic [3:0][7:0] seq;
        int              cnt;
        t_ctl_byte       e;
        while (!quiet && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_new_attr     <= want;
        i_current_attr <= cur;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        // transaction taken at this edge
        pair_cnt++;
        if (typed) begin
            cnt = typed_n;
            seq = typed_seq;
        end else begin
            cnt = predict_change(want, cur, wide_mode, seq);
        end
        for (int k = 0; k < cnt; k++) begin
            e.code = seq[k];
            e.last = (k == cnt - 1);
            pending_bytes.push_back(e);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        // let any unexpected byte still in flight reach the checker
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        wide_mode = w;
    endtask

    initial begin
        t_dir_row        rows [$];
        logic [12:0]     want;
        logic [12:0]     cur;
        int              r;
        logic [3:0][7:0] none;
        none = '0;

        rows.push_back(vec(1'b0, 13'h0007, 13'h0007, 0));
        rows.push_back(vec(1'b0, pace_pkg::ATTR_NORMAL, 13'h0007, 0));
        rows.push_back(vec(1'b0, pace_pkg::ATTR_BGBLACK, 13'h0007, 1, 8'h90));
        rows.push_back(vec(1'b0, 13'h010F, 13'h0000, 2, pace_pkg::B_RVS_ON, 8'h05));
        rows.push_back(vec(1'b0, 13'h0003, 13'h0100, 2, pace_pkg::B_RVS_OFF, 8'h98));
        rows.push_back(vec(1'b0, 13'h0008, 13'h0000, 1, 8'h97));
        rows.push_back(vec(1'b0, 13'h0070, 13'h0000, -1));
        rows.push_back(vec(1'b0, 13'h0400, 13'h0400, -1));
        rows.push_back(vec(1'b0, 13'h1FFF, 13'h0000, -1));
        rows.push_back(vec(1'b0, 13'h0000, 13'h1FFF, -1));
        rows.push_back(vec(1'b0, 13'h0880, 13'h0000, -1));
        rows.push_back(vec(1'b0, 13'h0280, 13'h0000, 0));
        rows.push_back(vec(1'b1, 13'h0080, 13'h0000, 1, pace_pkg::B_FLASH_ON));
        rows.push_back(vec(1'b1, 13'h0000, 13'h0080, 1, pace_pkg::B_FLASH_OFF));
        rows.push_back(vec(1'b1, 13'h0200, 13'h0000, 1, pace_pkg::B_ULINE_ON));
        rows.push_back(vec(1'b1, 13'h0000, 13'h0200, 1, pace_pkg::B_ULINE_OFF));
        rows.push_back(vec(1'b1, 13'h0003, 13'h0000, 1, pace_pkg::B_CYAN_W));
        rows.push_back(vec(1'b1, 13'h0008, 13'h0000, 1, pace_pkg::B_DKGRAY_W));
        rows.push_back(vec(1'b1, 13'h038F, 13'h0000, 4, pace_pkg::B_RVS_ON,
                           pace_pkg::B_FLASH_ON, pace_pkg::B_ULINE_ON, 8'h05));
        rows.push_back(vec(1'b1, 13'h0000, 13'h0385, -1));
        rows.push_back(vec(1'b1, 13'h0300, 13'h0200, -1));
        rows.push_back(vec(1'b1, 13'h1FFF, 13'h1FFF, 0));
        rows.push_back(vec(1'b1, pace_pkg::ATTR_NORMAL, pace_pkg::ATTR_BGBLACK, 1, 8'h9B));
        rows.push_back(vec(1'b1, 13'h0007, 13'h0070, -1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].wide != wide_mode) begin
                set_mode(rows[i].wide);
            end
            send_pair(rows[i].want, rows[i].cur, rows[i].typed, int'(rows[i].n), rows[i].seq);
        end

        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph[0]);
            for (int i = 0; i < PHASE_PAIRS; i++) begin
                want = pick_attr();
                r    = $urandom_range(9);
                // mostly small edits of the wanted attribute, so that few bytes differ
                if (r < 2) begin
                    cur = want;
                end else if (r < 7) begin
                    cur = want ^ (13'h1 << $urandom_range(10));
                end else begin
                    cur = pick_attr();
                end
                send_pair(want, cur, 1'b0, 0, none);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (!hold_done && pair_cnt >= HOLD_AT) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            i_out_stall <= !quiet && ($urandom_range(99) < 33);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected byte %02h last %0b", o_out_byte, o_last);
                end
            end else begin
                got = pending_bytes.pop_front();
                if (got.code !== o_out_byte || got.last !== o_last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 got.code, got.last, o_out_byte, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
